// ===== design/pidc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the clamped PID controller.
// Used by pidc_mul, pidc_div and pid_controller_clamped; depends on nothing.

package pidc_pkg;

  // Field and datapath widths
  localparam int unsigned GainW    = 24;   // Q12.12 gains
  localparam int unsigned PeriodW  = 10;   // sample period
  localparam int unsigned LimW     = 11;   // output limits and drive
  localparam int unsigned SampleW  = 16;   // Q8.8 temperatures
  localparam int unsigned ErrW     = SampleW + 1;
  localparam int unsigned DeltaW   = ErrW + 1;
  localparam int unsigned IntegW   = 20;   // Q12.8 integrator
  localparam int unsigned LimShift = 8;    // limit to Q12.8
  localparam int unsigned MulAW    = GainW;
  localparam int unsigned MulBW    = IntegW;
  localparam int unsigned ProdW    = MulAW + MulBW + 1;
  localparam int unsigned KitW     = GainW + PeriodW;
  localparam int unsigned KitHiW   = KitW - MulAW;
  localparam int unsigned AccW     = 56;   // Q36.20 sum
  localparam int unsigned FracW    = 20;
  localparam int unsigned QW       = AccW - FracW;
  localparam int unsigned DivSteps = GainW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 2 * SampleW;
  localparam int unsigned OutDataW = 16;

  // Register reset values
  localparam logic [GainW-1:0]          PropGainRst  = 24'd122880;
  localparam logic [GainW-1:0]          IntGainRst   = 24'd819;
  localparam logic [GainW-1:0]          DerGainRst   = 24'd1638400;
  localparam logic [PeriodW-1:0]        PeriodRst    = 10'd1;
  localparam logic signed [LimW-1:0]    OutMaxRst    = 11'sd100;
  localparam logic signed [LimW-1:0]    OutMinRst    = -11'sd100;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INT_GAIN   = 3'd1,
    REG_DER_GAIN   = 3'd2,
    REG_PERIOD     = 3'd3,
    REG_OUT_MAX    = 3'd4,
    REG_OUT_MIN    = 3'd5
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INTEG,
    ST_KIT,
    ST_INTLO,
    ST_INTHI,
    ST_DERIV,
    ST_DRAIN,
    ST_ROUND,
    ST_CLAMP
  } state_e;

  // What to do with a product once it leaves the multiplier
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_KIT,      // store as integral gain times period
    MUL_CLR,      // load the accumulator
    MUL_ADD,      // add to the accumulator
    MUL_ADD_HI    // add to the accumulator, shifted by MulAW
  } mul_op_e;

  typedef struct packed {
    mul_op_e                  op;
    logic [MulAW-1:0]         a;   // unsigned operand
    logic signed [MulBW-1:0]  b;   // signed operand
  } mul_req_t;

endpackage

// ===== design/pidc_mul.sv =====
`timescale 1ns / 1ps
// Shared registered multiplier: unsigned 24 bit by signed 20 bit.
// Depends on pidc_pkg; the operation tag travels with the product.

module pidc_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pidc_pkg::mul_req_t                 req_i,
  output logic signed [pidc_pkg::ProdW-1:0]  prod_o,
  output pidc_pkg::mul_op_e                  op_o
);

  logic signed [pidc_pkg::ProdW-1:0] prod_d, prod_q;
  pidc_pkg::mul_op_e                 op_q;

  // Form the product with the unsigned operand zero-extended
  assign prod_d = $signed({1'b0, req_i.a}) * req_i.b;

  // Register tag and product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= pidc_pkg::MUL_NONE;
    end else begin
      op_q <= req_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;
  assign op_o   = op_q;

endmodule

// ===== design/pidc_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the derivative gain.
// Depends on pidc_pkg for the operand widths.

module pidc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [pidc_pkg::GainW-1:0]        dividend_i,
  input  logic [pidc_pkg::PeriodW-1:0]      divisor_i,
  output logic                              busy_o,
  output logic [pidc_pkg::GainW-1:0]        quot_o
);

  localparam int unsigned CntW = $clog2(pidc_pkg::DivSteps + 1);

  logic                              busy_d, busy_q;
  logic [CntW-1:0]                   cnt_d, cnt_q;
  logic [pidc_pkg::GainW-1:0]        quo_d, quo_q;
  logic [pidc_pkg::PeriodW-1:0]      rem_d, rem_q;
  logic [pidc_pkg::PeriodW-1:0]      dvs_d, dvs_q;
  logic [pidc_pkg::PeriodW:0]        rem_sh, rem_sub;
  logic                              fits;

  // Shift in the next dividend bit and trial-subtract the divisor
  assign rem_sh  = {rem_q, quo_q[pidc_pkg::GainW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(pidc_pkg::DivSteps);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d  = {quo_q[pidc_pkg::GainW-2:0], fits};
      rem_d  = fits ? rem_sub[pidc_pkg::PeriodW-1:0] : rem_sh[pidc_pkg::PeriodW-1:0];
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != CntW'(1));
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

// ===== design/pid_controller_clamped.sv =====
`timescale 1ns / 1ps
// Clamped PID controller: one drive value per setpoint/measured item.
// The sequencer waits on the derivative-gain divider before its last product, and it takes
// one item at a time: a new item is accepted only after the last drive value is loaded.
// The three gain products share one registered multiplier under the sequencer below.
// Reset (rst_ni low, asynchronous) restores register defaults and clears the integrator
// and the stored error. Depends on pidc_pkg, pidc_mul and pidc_div.

module pid_controller_clamped (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [pidc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [pidc_pkg::GainW-1:0]           cfg_data_i,
  // Input items
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [pidc_pkg::InDataW-1:0]         s_axis_tdata,  // [15:0] setpoint, [31:16] measured
  // Result items
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [pidc_pkg::OutDataW-1:0]        m_axis_tdata   // [10:0] drive, rest zero
);

  localparam int unsigned AccInW = pidc_pkg::IntegW + 1;

  // Configuration registers
  logic [pidc_pkg::GainW-1:0]        prop_gain_q, int_gain_q, der_gain_q;
  logic [pidc_pkg::PeriodW-1:0]      period_q;
  logic signed [pidc_pkg::LimW-1:0]  out_max_q, out_min_q;

  // Sequencer and datapath
  pidc_pkg::state_e                      state_d, state_q;
  logic signed [pidc_pkg::ErrW-1:0]      err_d, err_q, prev_d, prev_q;
  logic signed [pidc_pkg::DeltaW-1:0]    delta_d, delta_q;
  logic signed [pidc_pkg::IntegW-1:0]    integ_d, integ_q;
  logic [pidc_pkg::KitW-1:0]             kit_d, kit_q;
  logic signed [pidc_pkg::AccW-1:0]      acc_d, acc_q;
  logic signed [pidc_pkg::QW-1:0]        q_d, q_q;
  logic signed [pidc_pkg::LimW-1:0]      drive_d, drive_q;
  logic                                  out_vld_d, out_vld_q;

  logic                                  in_acc, out_load;
  logic [pidc_pkg::PeriodW-1:0]          t_eff;
  logic signed [pidc_pkg::SampleW-1:0]   sp, ms;
  logic signed [AccInW-1:0]              acc_in, int_hi, int_lo;
  logic signed [pidc_pkg::AccW-1:0]      prod_ext, round_sum;
  logic signed [pidc_pkg::QW-1:0]        q_hi, q_lo;

  pidc_pkg::mul_req_t                    mul_req;
  logic signed [pidc_pkg::ProdW-1:0]     mul_prod;
  pidc_pkg::mul_op_e                     mul_op;
  logic                                  div_busy;
  logic [pidc_pkg::GainW-1:0]            kd_t;

  assign sp     = s_axis_tdata[pidc_pkg::SampleW-1:0];
  assign ms     = s_axis_tdata[pidc_pkg::InDataW-1:pidc_pkg::SampleW];
  assign t_eff  = (period_q == '0) ? pidc_pkg::PeriodW'(1) : period_q;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q <= pidc_pkg::PropGainRst;
      int_gain_q  <= pidc_pkg::IntGainRst;
      der_gain_q  <= pidc_pkg::DerGainRst;
      period_q    <= pidc_pkg::PeriodRst;
      out_max_q   <= pidc_pkg::OutMaxRst;
      out_min_q   <= pidc_pkg::OutMinRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pidc_pkg::REG_PROP_GAIN: prop_gain_q <= cfg_data_i;
        pidc_pkg::REG_INT_GAIN:  int_gain_q  <= cfg_data_i;
        pidc_pkg::REG_DER_GAIN:  der_gain_q  <= cfg_data_i;
        pidc_pkg::REG_PERIOD:    period_q    <= cfg_data_i[pidc_pkg::PeriodW-1:0];
        pidc_pkg::REG_OUT_MAX:   out_max_q   <= cfg_data_i[pidc_pkg::LimW-1:0];
        pidc_pkg::REG_OUT_MIN:   out_min_q   <= cfg_data_i[pidc_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier and derivative-gain divider
  pidc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .prod_o (mul_prod),
    .op_o   (mul_op)
  );

  pidc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .dividend_i (der_gain_q),
    .divisor_i  (t_eff),
    .busy_o     (div_busy),
    .quot_o     (kd_t)
  );

  // Integrator update and its limits scaled into Q12.8
  assign acc_in = AccInW'(integ_q) + AccInW'(err_q);
  assign int_hi = AccInW'($signed({out_max_q, {pidc_pkg::LimShift{1'b0}}}));
  assign int_lo = AccInW'($signed({out_min_q, {pidc_pkg::LimShift{1'b0}}}));

  // Truncate the sum toward zero and clamp it to the output limits
  assign round_sum = acc_q + (acc_q[pidc_pkg::AccW-1]
                     ? pidc_pkg::AccW'((64'd1 << pidc_pkg::FracW) - 64'd1)
                     : pidc_pkg::AccW'(0));
  assign q_hi      = pidc_pkg::QW'(out_max_q);
  assign q_lo      = pidc_pkg::QW'(out_min_q);
  assign out_load  = (state_q == pidc_pkg::ST_CLAMP) && (!out_vld_q || m_axis_tready);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pidc_pkg::ST_IDLE:  if (in_acc) state_d = pidc_pkg::ST_INTEG;
      pidc_pkg::ST_INTEG: state_d = pidc_pkg::ST_KIT;
      pidc_pkg::ST_KIT:   state_d = pidc_pkg::ST_INTLO;
      pidc_pkg::ST_INTLO: state_d = pidc_pkg::ST_INTHI;
      pidc_pkg::ST_INTHI: state_d = pidc_pkg::ST_DERIV;
      pidc_pkg::ST_DERIV: if (!div_busy) state_d = pidc_pkg::ST_DRAIN;
      pidc_pkg::ST_DRAIN: state_d = pidc_pkg::ST_ROUND;
      pidc_pkg::ST_ROUND: state_d = pidc_pkg::ST_CLAMP;
      pidc_pkg::ST_CLAMP: if (out_load) state_d = pidc_pkg::ST_IDLE;
      default:            state_d = pidc_pkg::ST_IDLE;
    endcase
  end

  // Multiplier requests issued by the sequencer
  always_comb begin
    mul_req.op = pidc_pkg::MUL_NONE;
    mul_req.a  = '0;
    mul_req.b  = '0;
    case (state_q)
      pidc_pkg::ST_INTEG: begin
        mul_req.op = pidc_pkg::MUL_KIT;
        mul_req.a  = int_gain_q;
        mul_req.b  = $signed(pidc_pkg::MulBW'(t_eff));
      end
      pidc_pkg::ST_KIT: begin
        mul_req.op = pidc_pkg::MUL_CLR;
        mul_req.a  = prop_gain_q;
        mul_req.b  = pidc_pkg::MulBW'(err_q);
      end
      pidc_pkg::ST_INTLO: begin
        mul_req.op = pidc_pkg::MUL_ADD;
        mul_req.a  = kit_q[pidc_pkg::MulAW-1:0];
        mul_req.b  = integ_q;
      end
      pidc_pkg::ST_INTHI: begin
        mul_req.op = pidc_pkg::MUL_ADD_HI;
        mul_req.a  = pidc_pkg::MulAW'(kit_q[pidc_pkg::KitW-1:pidc_pkg::MulAW]);
        mul_req.b  = integ_q;
      end
      pidc_pkg::ST_DERIV: begin
        if (!div_busy) begin
          mul_req.op = pidc_pkg::MUL_ADD;
          mul_req.a  = kd_t;
          mul_req.b  = pidc_pkg::MulBW'(delta_q);
        end
      end
      default: ;
    endcase
  end

  // Datapath register updates
  assign prod_ext = pidc_pkg::AccW'(mul_prod);

  always_comb begin
    err_d     = err_q;
    prev_d    = prev_q;
    delta_d   = delta_q;
    integ_d   = integ_q;
    kit_d     = kit_q;
    acc_d     = acc_q;
    q_d       = q_q;
    drive_d   = drive_q;
    out_vld_d = out_vld_q;

    if (m_axis_tvalid && m_axis_tready) out_vld_d = 1'b0;

    case (state_q)
      pidc_pkg::ST_IDLE: begin
        if (in_acc) err_d = pidc_pkg::ErrW'(sp) - pidc_pkg::ErrW'(ms);
      end
      pidc_pkg::ST_INTEG: begin
        if (acc_in >= int_hi)      integ_d = pidc_pkg::IntegW'(int_hi);
        else if (acc_in <= int_lo) integ_d = pidc_pkg::IntegW'(int_lo);
        else                       integ_d = pidc_pkg::IntegW'(acc_in);
        delta_d = pidc_pkg::DeltaW'(err_q) - pidc_pkg::DeltaW'(prev_q);
        prev_d  = err_q;
      end
      pidc_pkg::ST_ROUND: begin
        q_d = round_sum[pidc_pkg::AccW-1:pidc_pkg::FracW];
      end
      pidc_pkg::ST_CLAMP: begin
        if (out_load) begin
          if (q_q >= q_hi)      drive_d = out_max_q;
          else if (q_q <= q_lo) drive_d = out_min_q;
          else                  drive_d = pidc_pkg::LimW'(q_q);
          out_vld_d = 1'b1;
        end
      end
      default: ;
    endcase

    // Retire the product leaving the multiplier
    case (mul_op)
      pidc_pkg::MUL_KIT:    kit_d = pidc_pkg::KitW'(mul_prod);
      pidc_pkg::MUL_CLR:    acc_d = prod_ext;
      pidc_pkg::MUL_ADD:    acc_d = acc_q + prod_ext;
      pidc_pkg::MUL_ADD_HI: acc_d = acc_q + (prod_ext <<< pidc_pkg::MulAW);
      default: ;
    endcase
  end

  // Control state and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pidc_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
      integ_q   <= '0;
      prev_q    <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      integ_q   <= integ_d;
      prev_q    <= prev_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    delta_q <= delta_d;
    kit_q   <= kit_d;
    acc_q   <= acc_d;
    q_q     <= q_d;
    drive_q <= drive_d;
  end

  assign s_axis_tready = (state_q == pidc_pkg::ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = pidc_pkg::OutDataW'($unsigned(drive_q));

  // The divider must be free whenever a new item starts it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !div_busy)
    else $error("divider busy at input accept");

  // A new result appears only out of the clamp step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == pidc_pkg::ST_CLAMP))
    else $error("result loaded outside clamp step");

  // The gain-times-period product returns exactly when the sequencer expects it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_op == pidc_pkg::MUL_KIT) |-> (state_q == pidc_pkg::ST_KIT))
    else $error("integral gain product out of step");

  // With ordered limits the freshly updated integrator lies between them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pidc_pkg::ST_KIT && out_max_q >= out_min_q) |->
      (AccInW'(integ_q) <= int_hi && AccInW'(integ_q) >= int_lo))
    else $error("integrator outside its limits");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pid_controller_clamped: a directed plan, then random phases,
// drives checked against a fixed-point predictor or typed-in value. Depends on pidc_pkg.

module tb;
  import pidc_pkg::*;

  localparam int unsigned ClkHalf      = 5;
  localparam int unsigned ResetCycles  = 10;
  localparam int unsigned SettleCycles = 40;    // idle time once every owed drive is out
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned PhaseItems   = 250;
  localparam int unsigned RandPhases   = 6;
  localparam int unsigned MaxGap       = 40;
  localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CfgIdxW-1:0]       idx;
    logic [GainW-1:0]         data;
    logic [SampleW-1:0]       setpoint;
    logic [SampleW-1:0]       measured;
    logic                     has_fixed;
    logic signed [LimW-1:0]   fixed;
  } stim_row_t;

  // DUT ports
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i     = '0;
  logic [GainW-1:0]       cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataW-1:0]     s_axis_tdata  = '0;  // [15:0] setpoint, [31:16] measured
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataW-1:0]    m_axis_tdata;        // [10:0] drive, rest zero

  // Hand-typed drive value travelling alongside the item on the bus
  logic                   fixed_valid = 1'b0;
  logic signed [LimW-1:0] fixed_drive = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  int          fails          = 0;

  // Controller mirror: registers and state
  logic [GainW-1:0]       gain_p, gain_i, gain_d;
  logic [PeriodW-1:0]     period;
  logic signed [LimW-1:0] drive_max, drive_min;
  longint                 integ_q88, last_err;

  logic signed [LimW-1:0] drive_expected_q[$];
  stim_row_t              plan[$];

  pid_controller_clamped dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #(ClkHalf) clk_i = 1'b1;
    #(ClkHalf) clk_i = 1'b0;
  end

  function automatic longint clamp_to(input longint v, input longint upper, input longint lower);
    if (v >= upper) return upper;
    if (v <= lower) return lower;
    return v;
  endfunction

  // Advance the controller mirror by one sample and return its drive
  function automatic logic signed [LimW-1:0] predict_drive(input logic signed [SampleW-1:0] sp,
                                                           input logic signed [SampleW-1:0] ms);
    longint hi, lo, t, err, acc, delta, ki_t, kd_t, s, q;
    hi    = longint'(drive_max);
    lo    = longint'(drive_min);
    t     = (period == '0) ? 1 : longint'(period);
    err   = longint'(sp) - longint'(ms);
    acc   = clamp_to(integ_q88 + err, hi * 256, lo * 256);
    delta = err - last_err;
    ki_t  = longint'(gain_i) * t;
    kd_t  = longint'(gain_d) / t;
    s     = longint'(gain_p) * err + ki_t * acc + kd_t * delta;
    // truncate toward zero, dropping the 20 fraction bits
    q = (s < 0) ? -((-s) >>> FracW) : (s >>> FracW);
    q = clamp_to(q, hi, lo);
    integ_q88 = acc;
    last_err  = err;
    return q[LimW-1:0];
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] data);
    case (idx)
      REG_PROP_GAIN: gain_p    = data;
      REG_INT_GAIN:  gain_i    = data;
      REG_DER_GAIN:  gain_d    = data;
      REG_PERIOD:    period    = data[PeriodW-1:0];
      REG_OUT_MAX:   drive_max = data[LimW-1:0];
      REG_OUT_MIN:   drive_min = data[LimW-1:0];
      default: ;
    endcase
  endfunction

  function automatic stim_row_t row_sample(input logic [SampleW-1:0] sp,
                                           input logic [SampleW-1:0] ms,
                                           input logic has_fixed,
                                           input logic signed [LimW-1:0] fixed);
    stim_row_t r;
    r = '{ROW_SAMPLE, '0, '0, sp, ms, has_fixed, fixed};
    return r;
  endfunction

  function automatic stim_row_t row_write(input logic [CfgIdxW-1:0] idx,
                                          input logic [GainW-1:0] data);
    stim_row_t r;
    r = '{ROW_WRITE, idx, data, '0, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic logic [GainW-1:0] pick_gain(input int unsigned typical_max);
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return GainW'($urandom);
      default: return GainW'($urandom_range(0, typical_max));
    endcase
  endfunction

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 65; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      default:   begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  // Drop valid, drain every owed drive value, then let the block fall idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (drive_expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write one register; the caller keeps the enable high across back-to-back writes
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
  endtask

  task automatic send_sample(input logic [SampleW-1:0] sp, input logic [SampleW-1:0] ms,
                             input logic has_fixed, input logic signed [LimW-1:0] fixed);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, MaxGap);
    cfg_we_i <= 1'b0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ms, sp};
    fixed_valid   <= has_fixed;
    fixed_drive   <= fixed;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Receiver: stall at random per the current idling mode
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Predict on every accepted item, check every accepted drive, watch for a hang
  always @(posedge clk_i) begin
    logic signed [LimW-1:0] want;
    logic                   moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = predict_drive(s_axis_tdata[SampleW-1:0], s_axis_tdata[InDataW-1:SampleW]);
        if (fixed_valid) want = fixed_drive;
        drive_expected_q.push_back(want);
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (drive_expected_q.size() == 0) begin
          $display("%0t: unexpected drive, expected none, actual %0d (tdata %h)", $time,
                   $signed(m_axis_tdata[LimW-1:0]), m_axis_tdata);
          fails++;
        end else begin
          want = drive_expected_q.pop_front();
          if (m_axis_tdata !== {{(OutDataW-LimW){1'b0}}, want}) begin
            $display("%0t: drive mismatch, expected %0d, actual %0d (tdata %h)", $time,
                     want, $signed(m_axis_tdata[LimW-1:0]), m_axis_tdata);
            fails++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("pid_controller_clamped regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [SampleW-1:0] sp, ms;
    int                 base, span, offs, hi, lo, tmp;

    // Mirror starts at the reset values
    gain_p    = PropGainRst;
    gain_i    = IntGainRst;
    gain_d    = DerGainRst;
    period    = PeriodRst;
    drive_max = OutMaxRst;
    drive_min = OutMinRst;
    integ_q88 = 0;
    last_err  = 0;
    offs      = 0;

    // Directed plan: reset defaults, zero gains, full gains, zero period, crossed limits
    plan.push_back(row_sample(16'h0000, 16'h0000, 1'b1, 11'sd0));
    plan.push_back(row_sample(16'h7FFF, 16'h8000, 1'b1, 11'sd100));
    plan.push_back(row_sample(16'h8000, 16'h7FFF, 1'b1, -11'sd100));
    plan.push_back(row_sample(16'h8000, 16'h8000, 1'b0, '0));
    plan.push_back(row_sample(16'h7FFF, 16'h7FFF, 1'b0, '0));
    plan.push_back(row_sample(16'h0100, 16'h0000, 1'b0, '0));
    plan.push_back(row_sample(16'h0000, 16'h0001, 1'b0, '0));
    plan.push_back(row_sample(16'h0001, 16'h0000, 1'b0, '0));
    plan.push_back(row_write(REG_PROP_GAIN, '0));
    plan.push_back(row_write(REG_INT_GAIN, '0));
    plan.push_back(row_write(REG_DER_GAIN, '0));
    plan.push_back(row_write(REG_OUT_MAX, GainW'(1000)));
    plan.push_back(row_write(REG_OUT_MIN, GainW'(-1000)));
    plan.push_back(row_sample(16'h7FFF, 16'h8000, 1'b1, 11'sd0));
    plan.push_back(row_sample(16'h8000, 16'h7FFF, 1'b1, 11'sd0));
    plan.push_back(row_write(REG_PROP_GAIN, 24'hFFFFFF));
    plan.push_back(row_write(REG_INT_GAIN, 24'hFFFFFF));
    plan.push_back(row_write(REG_DER_GAIN, 24'hFFFFFF));
    plan.push_back(row_write(REG_PERIOD, 24'd1023));
    plan.push_back(row_sample(16'h7FFF, 16'h8000, 1'b1, 11'sd1000));
    plan.push_back(row_sample(16'h8000, 16'h7FFF, 1'b0, '0));
    plan.push_back(row_sample(16'h0000, 16'h0000, 1'b0, '0));
    // zero period with junk above the field, limits crossed, spare indexes poked
    plan.push_back(row_write(REG_PERIOD, 24'hABCC00));
    plan.push_back(row_write(REG_OUT_MAX, GainW'(-5)));
    plan.push_back(row_write(REG_OUT_MIN, GainW'(5)));
    plan.push_back(row_write(RegUnusedLo, 24'h123456));
    plan.push_back(row_write(RegUnusedHi, 24'hFFFFFF));
    plan.push_back(row_sample(16'h0000, 16'h0000, 1'b0, '0));
    plan.push_back(row_sample(16'h0100, 16'h0000, 1'b0, '0));
    plan.push_back(row_sample(16'h0000, 16'h0100, 1'b0, '0));
    plan.push_back(row_sample(16'h1234, 16'h1200, 1'b0, '0));

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed plan
    set_idling(IDLE_NONE);
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (i == 0 || plan[i-1].kind == ROW_SAMPLE) settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].setpoint, plan[i].measured, plan[i].has_fixed, plan[i].fixed);
      end
    end

    // Random phases: fresh settings and idling each time
    for (int ph = 0; ph < RandPhases; ph++) begin
      settle();
      write_reg(REG_PROP_GAIN, pick_gain(262144));
      write_reg(REG_INT_GAIN, pick_gain(4096));
      write_reg(REG_DER_GAIN, pick_gain(2097152));
      case ($urandom_range(0, 9))
        0:       write_reg(REG_PERIOD, GainW'($urandom) & 24'hFFFC00);
        1:       write_reg(REG_PERIOD, (GainW'($urandom) & 24'hFFFC00) |
                                       GainW'($urandom_range(1, 1023)));
        default: write_reg(REG_PERIOD, GainW'($urandom_range(1, 8)));
      endcase
      hi = int'($urandom_range(0, 2000)) - 1000;
      lo = int'($urandom_range(0, 2000)) - 1000;
      // keep the limits ordered most of the time, crossed now and then
      if ((hi < lo) == ($urandom_range(0, 99) < 85)) begin
        tmp = hi;
        hi  = lo;
        lo  = tmp;
      end
      write_reg(REG_OUT_MAX, GainW'(hi));
      write_reg(REG_OUT_MIN, GainW'(lo));
      if ($urandom_range(0, 2) == 0) write_reg(RegUnusedLo + CfgIdxW'($urandom_range(0, 1)),
                                               GainW'($urandom));
      set_idling(idle_mode_e'(ph % 4));

      repeat (PhaseItems) begin
        if ($urandom_range(0, 99) < 20) begin
          sp = SampleW'($urandom);
          ms = SampleW'($urandom);
        end else begin
          // plausible temperatures, error held steady at times to wind the integrator
          base = int'($urandom_range(0, 24000)) - 12000;
          case ($urandom_range(0, 3))
            0:       span = 16;
            1:       span = 256;
            2:       span = 2048;
            default: span = 16384;
          endcase
          if ($urandom_range(0, 99) >= 30) offs = int'($urandom_range(0, 2 * span)) - span;
          sp = SampleW'(base);
          ms = SampleW'(base - offs);
        end
        send_sample(sp, ms, 1'b0, '0);
      end
    end

    settle();
    if (fails == 0) begin
      $display("pid_controller_clamped regression: pass");
    end else begin
      $display("pid_controller_clamped regression: fail");
    end
    $finish;
  end

endmodule
